### src/nlbf_pkg.sv
// Shared types, command codes and helper functions for the nibble link block framer.
// No dependencies; every other file imports this package.
package nlbf_pkg;

  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_EOB  = 2'd1;
  localparam logic [1:0] CMD_ACK  = 2'd2;
  localparam logic [1:0] CMD_EOT  = 2'd3;

  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int STEP_W = 4;

  localparam logic [2:0] SYM_IDLE  = 3'd0;
  localparam logic [2:0] SYM_START = 3'd1;
  localparam logic [2:0] SYM_CSUM  = 3'd2;
  localparam logic [2:0] SYM_END   = 3'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] starts;
    logic [1:0] hi;
    logic [1:0] lo;
    logic [7:0] checksum;
    logic       accepted;
  } job_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] symbol;
    logic       accepted;
    logic       last;
  } result_t;

  function automatic logic [3:0] hex_value(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

  function automatic logic [2:0] pop4(logic [3:0] v);
    return 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
  endfunction

  // Result number step of the frame that a job expands into.
  function automatic result_t seq_result(job_t job, logic [STEP_W-1:0] step);
    result_t r;
    logic [STEP_W-1:0] pre;
    logic [STEP_W-1:0] t;
    logic [1:0] grp;
    r = '0;
    pre = STEP_W'({job.starts, 1'b0});
    t = step - pre;
    grp = 2'd0;
    case (job.op)
      CMD_DATA: begin
        if (step < pre) begin
          r.symbol = step[0] ? SYM_IDLE : SYM_START;
        end else begin
          case (t[1:0])
            2'd0: r.symbol = {1'b1, job.hi};
            2'd2: r.symbol = {1'b1, job.lo};
            2'd3: r.last = 1'b1;
            default: r.symbol = SYM_IDLE;
          endcase
        end
      end
      CMD_EOB: begin
        case (step)
          4'd0: r.symbol = SYM_CSUM;
          4'd2: grp = job.checksum[7:6];
          4'd5: grp = job.checksum[5:4];
          4'd8: grp = job.checksum[3:2];
          4'd11: grp = job.checksum[1:0];
          4'd14: r.symbol = SYM_END;
          4'd15: r.last = 1'b1;
          default: r.symbol = SYM_IDLE;
        endcase
        if (step == 4'd2 || step == 4'd5 || step == 4'd8 || step == 4'd11) begin
          r.symbol = {1'b1, grp};
        end
      end
      CMD_ACK: begin
        r.kind = 1'b1;
        r.accepted = job.accepted;
        r.last = 1'b1;
      end
      default: begin
        r.symbol = step[0] ? SYM_IDLE : SYM_END;
        r.last = (step[1:0] == 2'd3);
      end
    endcase
    return r;
  endfunction

endpackage

### src/nlbf_front.sv
// Front end: accepts requests, tracks block state and checksum, builds jobs.
// Depends on nlbf_pkg.
module nlbf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  logic [1:0]    command,
  input  logic [7:0]    character,
  input  logic          final_block,
  input  logic          error_pin,
  output logic          job_valid,
  input  logic          job_ready,
  output nlbf_pkg::job_t job
);
  import nlbf_pkg::*;

  logic [7:0] block_checksum;
  logic       block_open;
  logic [3:0] value;
  logic       accept;

  assign value      = hex_value(character);
  assign item_ready = job_ready;
  assign job_valid  = item_valid;
  assign accept     = item_valid && job_ready;

  always_comb begin
    job = '0;
    job.op = command;
    case (command)
      CMD_DATA: begin
        job.starts = block_open ? 2'd0 : (final_block ? 2'd2 : 2'd1);
        job.hi = value[3:2];
        job.lo = value[1:0];
      end
      CMD_EOB: job.checksum = block_checksum;
      CMD_ACK: job.accepted = !error_pin;
      default: job.checksum = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_checksum <= 8'd0;
      block_open <= 1'b0;
    end else if (accept) begin
      case (command)
        CMD_DATA: begin
          block_open <= 1'b1;
          block_checksum <= block_checksum + 8'(pop4(value));
        end
        CMD_EOB, CMD_EOT: begin
          block_open <= 1'b0;
          block_checksum <= 8'd0;
        end
        default: block_open <= block_open;
      endcase
    end
  end

endmodule

### src/nlbf_queue.sv
// Short job queue between the front end and the symbol sequencer.
// Depends on nlbf_pkg for the job type.
module nlbf_queue #(
  parameter int DEPTH = nlbf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  nlbf_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output nlbf_pkg::job_t pop_job
);
  import nlbf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

### src/nlbf_back.sv
// Back end: steps through the frame of the head job, one result per cycle while the
// output is not stalled, into a registered output stage. Depends on nlbf_pkg.
module nlbf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  nlbf_pkg::job_t job,
  output logic           result_valid,
  input  logic           result_ready,
  output nlbf_pkg::result_t result
);
  import nlbf_pkg::*;

  logic [STEP_W-1:0] step;
  result_t           current;
  logic              load;

  assign current   = seq_result(job, step);
  assign load      = job_valid && (!result_valid || result_ready);
  assign job_ready = load && current.last;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= current;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
      step <= current.last ? '0 : step + 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

### src/nibble_link_block_framer.sv
// Top level of the nibble link block framer: front end, job queue, sequencer.
// Depends on nlbf_pkg, nlbf_front, nlbf_queue and nlbf_back.
//
//  Channel   Handshake                   Payload
//  request   item_valid / item_ready     command, character, final_block, error_pin
//  result    result_valid / result_ready kind, symbol, block_accepted, last
//
// The sequencer emits one result per cycle while the result side does not stall. Results
// per request: data 4, 6 or 8 (with start symbols), end of block 16,
// acknowledge 1, end of transfer 4. The front end takes a request in any cycle in which the
// job queue has room; the queue holds up to QUEUE_DEPTH jobs, the one in progress included.
// Reset clears the block state, empties the queue and drops any pending result.
// A stall on the result side holds the output register and the sequencer step.
module nibble_link_block_framer #(
  parameter int QUEUE_DEPTH = nlbf_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic [1:0] command,
  input  logic [7:0] character,
  input  logic       final_block,
  input  logic       error_pin,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       kind,
  output logic [2:0] symbol,
  output logic       block_accepted,
  output logic       last
);
  import nlbf_pkg::*;

  // Jobs leave the front end already classified: the checksum snapshot,
  // start-symbol count and verdict are fixed at the moment of the request.
  job_t    front_job;
  logic    front_valid;
  logic    front_ready;
  job_t    head_job;
  logic    head_valid;
  logic    head_ready;
  result_t result;

  nlbf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .command     (command),
    .character   (character),
    .final_block (final_block),
    .error_pin   (error_pin),
    .job_valid   (front_valid),
    .job_ready   (front_ready),
    .job         (front_job)
  );

  nlbf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_job    (head_job)
  );

  // The sequencer pops a job only on the cycle that loads its last result.
  nlbf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (head_valid),
    .job_ready    (head_ready),
    .job          (head_job),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign kind           = result.kind;
  assign symbol         = result.symbol;
  assign block_accepted = result.accepted;
  assign last           = result.last;

  // A full queue must always have a job for the sequencer to work on.
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> head_valid)
    else $error("queue full but no head job");

  // A verdict is always a single result with an idle symbol.
  a_verdict_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind |-> last && symbol == SYM_IDLE)
    else $error("verdict result malformed");

  // Line symbols never carry a verdict bit.
  a_symbol_no_verdict: assert property (@(posedge clk) disable iff (rst)
    result_valid && !kind |-> !block_accepted)
    else $error("line symbol with verdict bit");

  // A job is popped only together with loading a result that ends it.
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    head_valid && head_ready |=> result_valid && last)
    else $error("job popped without final result");

endmodule

### tb/sv/nibble_link_block_framer_tb.sv
// Self-checking testbench for the nibble link block framer: a directed table, then random
// block sequences under four idling phases. Depends on nlbf_pkg and nibble_link_block_framer.
module nibble_link_block_framer_tb;
  import nlbf_pkg::*;

  // A request as the sender drives it. When typed is set, the expected frame is
  // built from exp_acc (acknowledge) or exp_csum (end of block) instead of the
  // predictor, since those values can be read straight off the command sequence.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic       fin;
    logic       err;
    logic       typed;
    logic       exp_acc;
    logic [7:0] exp_csum;
  } req_row_t;

  // Cycles without any accepted request or result before the run is declared hung.
  localparam int QUIET_LIMIT = 4000;
  // Cycles to keep watching the result port once nothing more is expected.
  localparam int TAIL_CYCLES = 40;
  localparam int DIR_ROWS = 25;

  // Directed table. It opens right after reset with an end of block on no open
  // block, then covers every command, the hex digit extremes in both cases,
  // the non-hex neighbors of both letter ranges and the byte below the digits,
  // the double start of a final block, an acknowledge in the middle of a block,
  // back-to-back end of block, and an end of transfer that abandons an open block.
  localparam req_row_t DIR_TAB [DIR_ROWS] = '{
    '{CMD_EOB,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00},
    '{CMD_ACK,  8'hFF, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00},
    '{CMD_ACK,  8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00},
    '{CMD_DATA, 8'h30, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h46, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h66, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h41, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h61, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_EOB,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h46, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_EOB,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 8'h04},
    '{CMD_DATA, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h47, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h2F, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h40, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h60, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h67, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_ACK,  8'h55, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00},
    '{CMD_EOB,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00},
    '{CMD_EOB,  8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00},
    '{CMD_DATA, 8'h37, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_EOT,  8'hA5, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00},
    '{CMD_EOT,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
    '{CMD_DATA, 8'h35, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00}
  };

  // Clock and every block input start at a known value at time zero.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  logic [1:0] command = CMD_DATA;
  logic [7:0] character = 8'h00;
  logic       final_block = 1'b0;
  logic       error_pin = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic       kind;
  logic [2:0] symbol;
  logic       block_accepted;
  logic       last;

  // Predictor state: the running block checksum and whether a block is open.
  logic [7:0] blk_csum = 8'h00;
  logic       blk_open = 1'b0;
  // Line symbols and verdicts still owed by the block, oldest first.
  result_t    frame_q[$];

  // Idling controls, in percent, changed between phases.
  int send_idle_pct = 0;
  int stall_pct = 0;

  int err_cnt = 0;
  int res_cnt = 0;
  int quiet_cnt = 0;
  int cmd_cnt [4] = '{0, 0, 0, 0};
  int wrap_cnt = 0;
  int dbl_start_cnt = 0;

  result_t got_res;
  result_t want_res;

  always #4 clk = ~clk;

  nibble_link_block_framer u_dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .command        (command),
    .character      (character),
    .final_block    (final_block),
    .error_pin      (error_pin),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .kind           (kind),
    .symbol         (symbol),
    .block_accepted (block_accepted),
    .last           (last)
  );

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  function automatic void push_res(logic k, logic [2:0] s, logic acc);
    result_t r;
    r = '0;
    r.kind = k;
    r.symbol = s;
    r.accepted = acc;
    frame_q = {frame_q, r};
  endfunction

  // Every line symbol is followed by an idle symbol.
  function automatic void push_pair(logic [2:0] s);
    push_res(1'b0, s, 1'b0);
    push_res(1'b0, SYM_IDLE, 1'b0);
  endfunction

  // The final result of each request carries the last flag.
  function automatic void mark_last();
    result_t r;
    r = frame_q.pop_back();
    r.last = 1'b1;
    frame_q = {frame_q, r};
  endfunction

  // Value of an ASCII hex digit; any other byte counts as zero. Inside both
  // letter ranges the low nibble equals the digit's offset from 9.
  function automatic logic [3:0] digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) return 4'(c[3:0] + 4'd9);
    return 4'd0;
  endfunction

  // Checksum frame: checksum marker, four clocked 2-bit groups from the top,
  // each with an extra idle, then the end marker.
  function automatic void push_csum_frame(logic [7:0] cs);
    push_pair(SYM_CSUM);
    for (int g = 3; g >= 0; g--) begin
      push_pair({1'b1, cs[2*g +: 2]});
      push_res(1'b0, SYM_IDLE, 1'b0);
    end
    push_pair(SYM_END);
    mark_last();
  endfunction

  function automatic void predict_frame(req_row_t r);
    logic [3:0] v;
    logic [8:0] sum;
    case (r.cmd)
      CMD_DATA: begin
        v = digit_value(r.ch);
        // Opening a block sends one start symbol, or two when it is the final block.
        if (!blk_open) begin
          push_pair(SYM_START);
          if (r.fin) begin
            push_pair(SYM_START);
            dbl_start_cnt++;
          end
          blk_open = 1'b1;
        end
        push_pair({1'b1, v[3:2]});
        push_pair({1'b1, v[1:0]});
        mark_last();
        sum = {1'b0, blk_csum} + 9'($countones(v));
        if (sum[8]) wrap_cnt++;
        blk_csum = sum[7:0];
      end
      CMD_EOB: begin
        // With no block open the checksum frame goes out without a start symbol.
        push_csum_frame(blk_csum);
        blk_csum = 8'h00;
        blk_open = 1'b0;
      end
      CMD_ACK: begin
        push_res(1'b1, SYM_IDLE, ~r.err);
        mark_last();
      end
      default: begin
        // End of transfer drops any open block along with its checksum.
        push_pair(SYM_END);
        push_pair(SYM_END);
        mark_last();
        blk_csum = 8'h00;
        blk_open = 1'b0;
      end
    endcase
  endfunction

  // Typed rows push their written-in expectation but still move the state.
  function automatic void apply_typed(req_row_t r);
    if (r.cmd == CMD_ACK) begin
      push_res(1'b1, SYM_IDLE, r.exp_acc);
      mark_last();
    end else begin
      push_csum_frame(r.exp_csum);
      blk_csum = 8'h00;
      blk_open = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Drives one request and waits for it to be accepted. Every call starts at a
  // rising edge. Valid is only lowered when an idle gap is inserted, so a
  // request that follows directly never sees valid dropped and raised in the
  // same time step.
  task automatic send_req(req_row_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid  <= 1'b1;
    command     <= r.cmd;
    character   <= r.ch;
    final_block <= r.fin;
    error_pin   <= r.err;
    do @(posedge clk); while (!item_ready);
    cmd_cnt[r.cmd]++;
    if (r.typed) apply_typed(r);
    else predict_frame(r);
  endtask

  // Holds the request side idle until the block has delivered everything owed.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (frame_q.size() != 0);
  endtask

  // Mostly hex digits of either case, sometimes any byte at all.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    case ($urandom_range(2))
      0: return 8'(8'h30 + $urandom_range(9));
      1: return 8'(8'h41 + $urandom_range(5));
      default: return 8'(8'h61 + $urandom_range(5));
    endcase
  endfunction

  // A request with random content in every field but the command.
  function automatic req_row_t rand_req(logic [1:0] cmd);
    req_row_t r;
    r = '0;
    r.cmd = cmd;
    r.ch = 8'($urandom_range(255));
    r.fin = 1'($urandom_range(1));
    r.err = 1'($urandom_range(1));
    return r;
  endfunction

  // One long block of F digits in both cases: 4 per digit, so the 8-bit
  // checksum wraps past 255 before the block is closed.
  task automatic send_long_block();
    req_row_t r;
    for (int k = 0; k < 68; k++) begin
      r = rand_req(CMD_DATA);
      r.ch = $urandom_range(1) ? 8'h46 : 8'h66;
      send_req(r);
    end
    send_req(rand_req(CMD_EOB));
    send_req(rand_req(CMD_ACK));
  endtask

  // Random part of one phase. Most of it is well-formed blocks: a few data
  // requests, a close, and an acknowledge. The rest is noise, blocks cut off
  // by end of transfer, and blocks that run on into the next one unclosed.
  task automatic run_phase(int target);
    int sent;
    int n;
    req_row_t r;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(9) == 0) begin
        send_req(rand_req(2'($urandom_range(3))));
        sent++;
      end else begin
        n = 1 + $urandom_range(6);
        for (int k = 0; k < n; k++) begin
          r = rand_req(CMD_DATA);
          r.ch = pick_char();
          send_req(r);
        end
        sent += n;
        case ($urandom_range(9))
          0: begin
            send_req(rand_req(CMD_EOT));
            sent++;
          end
          1: ;
          default: begin
            send_req(rand_req(CMD_EOB));
            sent++;
          end
        endcase
        send_req(rand_req(CMD_ACK));
        sent++;
        if ($urandom_range(4) == 0) begin
          send_req(rand_req(CMD_EOT));
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // The receiver decides afresh at each edge whether to stall.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    if (err_cnt < 50) begin
      $display("mismatch on result %0d: %s is %0d, expected %0d", res_cnt, what, got, want);
    end
    err_cnt++;
  endtask

  // Each accepted result is checked field by field against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      got_res.kind = kind;
      got_res.symbol = symbol;
      got_res.accepted = block_accepted;
      got_res.last = last;
      if (frame_q.size() == 0) begin
        report_mismatch("result with none owed, symbol", got_res.symbol, 0);
      end else begin
        want_res = frame_q.pop_front();
        if (got_res.kind !== want_res.kind)
          report_mismatch("kind", got_res.kind, want_res.kind);
        if (got_res.symbol !== want_res.symbol)
          report_mismatch("symbol", got_res.symbol, want_res.symbol);
        if (got_res.accepted !== want_res.accepted)
          report_mismatch("block_accepted", got_res.accepted, want_res.accepted);
        if (got_res.last !== want_res.last)
          report_mismatch("last", got_res.last, want_res.last);
      end
      res_cnt++;
    end
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= QUIET_LIMIT) begin
      $display("watchdog: no request or result accepted in %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table with no idling on either side.
    for (int i = 0; i < DIR_ROWS; i++) send_req(DIR_TAB[i]);
    drain_results();

    // Phase one: no idling, including the checksum wrap block.
    send_long_block();
    run_phase(30);
    drain_results();

    // Phase two: the sender inserts an idle gap before about 60 in a hundred requests.
    send_idle_pct = 60;
    stall_pct = 0;
    run_phase(45);
    drain_results();

    // Phase three: the receiver stalls with a chance of about 60 percent.
    send_idle_pct = 0;
    stall_pct = 60;
    run_phase(45);
    drain_results();

    // Phase four: both sides idle with a chance of about 35 percent.
    send_idle_pct = 35;
    stall_pct = 35;
    run_phase(45);

    // Wait for every owed result, then watch the port a little longer for strays.
    item_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d data, %0d end of block, %0d acknowledge, %0d end of transfer requests",
             cmd_cnt[CMD_DATA], cmd_cnt[CMD_EOB], cmd_cnt[CMD_ACK], cmd_cnt[CMD_EOT]);
    $display("over four idling phases: %0d results checked, %0d checksum wraps, %0d double starts",
             res_cnt, wrap_cnt, dbl_start_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
